// ----- hdl/rld_pkg.sv -----
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types, register indexes and helpers of the Targa RLE line decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rld_pkg;

  // Register index, taken from paddr[2] (registers lie at byte addresses 0 and 4).
  localparam logic REG_LINE_WIDTH      = 1'b0;
  localparam logic REG_BYTES_PER_PIXEL = 1'b1;

  localparam logic [15:0] LINE_WIDTH_RESET      = 16'd1;
  localparam logic [2:0]  BYTES_PER_PIXEL_RESET = 3'd4;

  localparam logic [7:0] CTRL_LEN_MASK = 8'h7f;
  localparam logic [7:0] CTRL_RUN_BIT  = 8'h80;

  typedef struct packed {
    logic [15:0] line_width;
    logic [2:0]  bytes_per_pixel;
  } rld_cfg_t;

  typedef struct packed {
    logic        error_flag;
    logic        line_end;
    logic [7:0]  repeat_count;
    logic [31:0] pixel_value;
  } rld_result_t;

  // Effective pixel size: zero acts as one, anything above the maximum is clamped.
  function automatic logic [2:0] rld_pixel_bytes(input logic [2:0] bpp,
                                                 input logic [2:0] max_bytes);
    logic [2:0] b;
    b = bpp;
    if (b == 3'd0) begin
      b = 3'd1;
    end
    if (b > max_bytes) begin
      b = max_bytes;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/rld_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// rld_cfg_regs
// APB-style register file holding line width and bytes per pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module rld_cfg_regs
  import rld_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output rld_cfg_t         cfg_o
);

  logic [15:0] line_width_q;
  logic [2:0]  bpp_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RESET;
      bpp_q        <= BYTES_PER_PIXEL_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_LINE_WIDTH:      line_width_q <= pwdata[15:0];
        REG_BYTES_PER_PIXEL: bpp_q        <= pwdata[2:0];
        default:             line_width_q <= line_width_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LINE_WIDTH:      prdata = {16'd0, line_width_q};
      REG_BYTES_PER_PIXEL: prdata = {29'd0, bpp_q};
      default:             prdata = 32'd0;
    endcase
  end

  assign cfg_o.line_width      = line_width_q;
  assign cfg_o.bytes_per_pixel = bpp_q;

endmodule

`default_nettype wire

// ----- hdl/rld_parser.sv -----
// ----------------------------------------------------------------------------
// rld_parser
// Packet and line state of the decoder; turns one stream byte into at most
// one result per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rld_parser
  import rld_pkg::*;
#(
  parameter int MaxBytesPerPixel = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire rld_cfg_t    cfg_i,
  input  wire logic        accept_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        restart_i,
  output logic             res_valid_o,
  output rld_result_t      res_o
);

  localparam int AsmW = 8 * MaxBytesPerPixel;

  logic            ec_q, ec_d, cur_ec;
  logic            run_q, run_d, cur_run;
  logic [7:0]      left_q, left_d, cur_left;
  logic [7:0]      plen_q, plen_d, cur_plen;
  logic [AsmW-1:0] asm_q, asm_d, cur_asm, asm_new;
  logic [1:0]      pos_q, pos_d, cur_pos;
  logic [16:0]     lcnt_q, lcnt_d, cur_lcnt;
  logic            err_q, err_d, cur_err;

  logic [7:0]  len;
  logic [16:0] sum;
  logic [2:0]  pos_n;
  logic [2:0]  pb;
  logic [7:0]  left_n;

  assign pb = rld_pixel_bytes(cfg_i.bytes_per_pixel, 3'(MaxBytesPerPixel));

  always_comb begin
    // A restart clears the line state before the byte is looked at.
    if (restart_i) begin
      cur_ec   = 1'b1;
      cur_run  = 1'b0;
      cur_left = '0;
      cur_plen = '0;
      cur_asm  = '0;
      cur_pos  = '0;
      cur_lcnt = '0;
      cur_err  = 1'b0;
    end else begin
      cur_ec   = ec_q;
      cur_run  = run_q;
      cur_left = left_q;
      cur_plen = plen_q;
      cur_asm  = asm_q;
      cur_pos  = pos_q;
      cur_lcnt = lcnt_q;
      cur_err  = err_q;
    end

    len   = {1'b0, data_byte_i[6:0] & CTRL_LEN_MASK[6:0]} + 8'd1;
    sum   = cur_lcnt + 17'(len);
    pos_n = {1'b0, cur_pos} + 3'd1;
    for (int k = 0; k < MaxBytesPerPixel; k++) begin
      asm_new[8*k +: 8] = cur_asm[8*k +: 8] | ((cur_pos == 2'(k)) ? data_byte_i : 8'd0);
    end
    left_n = (cur_left != 8'd0) ? cur_left - 8'd1 : 8'd0;

    ec_d   = ec_q;
    run_d  = run_q;
    left_d = left_q;
    plen_d = plen_q;
    asm_d  = asm_q;
    pos_d  = pos_q;
    lcnt_d = lcnt_q;
    err_d  = err_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (accept_i) begin
      ec_d   = cur_ec;
      run_d  = cur_run;
      left_d = cur_left;
      plen_d = cur_plen;
      asm_d  = cur_asm;
      pos_d  = cur_pos;
      lcnt_d = cur_lcnt;
      err_d  = cur_err;
      if (!cur_err) begin
        if (cur_ec) begin
          if (sum > {1'b0, cfg_i.line_width}) begin
            // Packet overruns the line: one error result, then stay silent.
            err_d             = 1'b1;
            res_valid_o       = 1'b1;
            res_o.error_flag  = 1'b1;
          end else begin
            lcnt_d = sum;
            run_d  = |(data_byte_i & CTRL_RUN_BIT);
            plen_d = len;
            left_d = (|(data_byte_i & CTRL_RUN_BIT)) ? 8'd1 : len;
            asm_d  = '0;
            pos_d  = '0;
            ec_d   = 1'b0;
          end
        end else if (pos_n < pb) begin
          asm_d = asm_new;
          pos_d = pos_n[1:0];
        end else begin
          res_valid_o        = 1'b1;
          res_o.pixel_value  = 32'(asm_new);
          res_o.repeat_count = cur_run ? cur_plen : 8'd1;
          asm_d  = '0;
          pos_d  = '0;
          left_d = left_n;
          if (left_n == 8'd0) begin
            ec_d = 1'b1;
            if (cur_lcnt == {1'b0, cfg_i.line_width}) begin
              res_o.line_end = 1'b1;
              lcnt_d         = '0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ec_q   <= 1'b1;
      run_q  <= 1'b0;
      left_q <= '0;
      plen_q <= '0;
      asm_q  <= '0;
      pos_q  <= '0;
      lcnt_q <= '0;
      err_q  <= 1'b0;
    end else begin
      ec_q   <= ec_d;
      run_q  <= run_d;
      left_q <= left_d;
      plen_q <= plen_d;
      asm_q  <= asm_d;
      pos_q  <= pos_d;
      lcnt_q <= lcnt_d;
      err_q  <= err_d;
    end
  end

  // Once an overrun is seen, only a restart leaves the error state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q && !(accept_i && restart_i) |=> err_q)
    else $error("error state left without restart");

  // No result comes out while the error state holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q && !restart_i |-> !res_valid_o)
    else $error("result produced in error state");

  // A completed line resets the pixel count and awaits a control byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.line_end |=> (lcnt_q == 17'd0) && ec_q)
    else $error("line end did not restart the line");

endmodule

`default_nettype wire

// ----- hdl/rld_out_fifo.sv -----
// ----------------------------------------------------------------------------
// rld_out_fifo
// Two-entry result buffer; the head entry drives the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module rld_out_fifo
  import rld_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire rld_result_t push_data_i,
  input  wire logic        pop_ready_i,
  output logic             head_valid_o,
  output rld_result_t      head_o,
  output logic             full_o
);

  logic        v0_q, v0_d, v1_q, v1_d;
  rld_result_t r0_q, r0_d, r1_q, r1_d;
  logic        pop;

  assign pop          = v0_q & pop_ready_i;
  assign head_valid_o = v0_q;
  assign head_o       = r0_q;
  assign full_o       = v1_q;

  always_comb begin
    v0_d = v0_q;
    v1_d = v1_q;
    r0_d = r0_q;
    r1_d = r1_q;
    if (pop) begin
      v0_d = v1_q;
      r0_d = r1_q;
      v1_d = 1'b0;
    end
    if (push_i) begin
      if (!v0_d) begin
        v0_d = 1'b1;
        r0_d = push_data_i;
      end else begin
        v1_d = 1'b1;
        r1_d = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q <= r0_d;
    r1_q <= r1_d;
  end

  // The second entry is only ever occupied behind the head.
  assert property (@(posedge clk_i) disable iff (!rst_ni) v1_q |-> v0_q)
    else $error("second entry valid with empty head");

  // No push may arrive while both entries hold results.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !v1_q)
    else $error("push into full buffer");

endmodule

`default_nettype wire

// ----- hdl/tga_rle_line_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// tga_rle_line_decoder_unit
// Targa RLE line decoder: parses the compressed byte stream into run and raw
// pixels with repeat counts, checking each packet against the line width.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake             | Content
//  ---------+-----------+-----------------------+------------------------------
//  s_axis   | in        | tvalid/tready         | tdata: data_byte; tuser: restart
//  m_axis   | out       | tvalid/tready         | tdata: pixel_value, repeat_count;
//           |           |                       | tlast: line_end; tuser: error_flag
//  APB      | in/out    | psel/penable, pready  | line_width @0x0, bytes_per_pixel @0x4
//
// One stream byte is accepted per cycle while s_axis_tready_o is high; its result,
// if any, comes combinationally from the parser and is registered in the output
// buffer, whose head entry drives m_axis.
// s_axis_tready_o drops only while two results wait in the output buffer,
// so a stalled consumer can hold back at most two results before input stops.
// Reset is asynchronous and active low; it restores the register defaults
// (width 1, four bytes per pixel) and leaves the decoder awaiting a control byte.
// Bytes sent with restart set clear the line and error state first.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_line_decoder_unit
  import rld_pkg::*;
#(
  parameter int MaxBytesPerPixel = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic [0:0]  s_axis_tuser_i,   // [0] restart
  // Result stream.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,   // [31:0] pixel_value, [39:32] repeat_count
  output logic             m_axis_tlast_o,   // line_end
  output logic [0:0]       m_axis_tuser_o,   // [0] error_flag
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  rld_cfg_t    cfg;
  rld_result_t res;
  rld_result_t head;
  logic        res_valid;
  logic        fifo_full;
  logic        in_accept;

  assign s_axis_tready_o = !fifo_full;
  assign in_accept       = s_axis_tvalid_i & s_axis_tready_o;

  rld_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rld_parser #(
    .MaxBytesPerPixel (MaxBytesPerPixel)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (in_accept),
    .data_byte_i (s_axis_tdata_i),
    .restart_i   (s_axis_tuser_i[0]),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rld_out_fifo u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (res_valid),
    .push_data_i  (res),
    .pop_ready_i  (m_axis_tready_i),
    .head_valid_o (m_axis_tvalid_o),
    .head_o       (head),
    .full_o       (fifo_full)
  );

  assign m_axis_tdata_o    = {head.repeat_count, head.pixel_value};
  assign m_axis_tlast_o    = head.line_end;
  assign m_axis_tuser_o[0] = head.error_flag;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Targa RLE line decoder. A directed part covers
// register defaults, field extremes, overrun, zero and maximum line width,
// pixel size clamping and a pixel size change inside a packet. A random part
// then streams well-formed lines with noise and broken packets under several
// register settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rld_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 1000;  // quiet cycles before giving up
  localparam int unsigned DRAIN_CYCLES = 4;     // settling margin after the last expected result
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned PHASES       = 10;

  // Clock and reset.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  // Input stream.
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;  // [7:0] data_byte
  logic [0:0] s_axis_tuser  = '0;  // [0] restart

  // Result stream.
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // [31:0] pixel_value, [39:32] repeat_count
  logic        m_axis_tlast;       // line_end
  logic [0:0]  m_axis_tuser;       // [0] error_flag

  // Configuration port.
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  tga_rle_line_decoder_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tuser_o  (m_axis_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // --------------------------------------------------------------------------
  // Decoder prediction. This is an independent copy of the line parser state,
  // advanced once for every input transaction that the block accepts.
  // --------------------------------------------------------------------------
  rld_cfg_t    dec_cfg;
  logic        dec_await_ctrl;  // next byte is a packet control byte
  logic        dec_run;         // current packet is a run packet
  logic        dec_stuck;       // overrun seen, bytes are dropped until restart
  logic [7:0]  dec_left;        // pixels still to come in this packet
  logic [7:0]  dec_len;         // length of the current packet
  logic [31:0] dec_pixel;       // pixel bytes gathered so far
  logic [1:0]  dec_pos;         // next byte lane within the pixel
  logic [16:0] dec_count;       // pixels of the line claimed by packets so far

  rld_result_t pixel_expect_q[$];

  int unsigned decoded_items  = 0;  // accepted bytes that were not dropped
  int unsigned mismatch_count = 0;
  bit          steady_flow    = 1'b0;  // no stalls on either stream when set

  // A pixel size of zero behaves as one byte, anything above four as four.
  function automatic int unsigned eff_pixel_bytes(input logic [2:0] bpp);
    if (bpp == 3'd0) return 1;
    if (bpp > 3'd4) return 4;
    return int'(bpp);
  endfunction

  function automatic logic [7:0] ctrl_byte(input bit run, input int unsigned len);
    return (run ? CTRL_RUN_BIT : 8'h00) | (8'(len - 1) & CTRL_LEN_MASK);
  endfunction

  task automatic clear_line_state();
    dec_await_ctrl = 1'b1;
    dec_run        = 1'b0;
    dec_stuck      = 1'b0;
    dec_left       = '0;
    dec_len        = '0;
    dec_pixel      = '0;
    dec_pos        = '0;
    dec_count      = '0;
  endtask

  // Advances the prediction by one accepted byte and queues the pixel or
  // error result that it produces, if any.
  task automatic decode_byte(input logic [7:0] b, input logic restart);
    rld_result_t res;
    int unsigned len;
    int unsigned pos;
    if (restart) clear_line_state();
    if (dec_stuck) return;
    decoded_items++;
    res = '0;
    if (dec_await_ctrl) begin
      len = int'(b & CTRL_LEN_MASK) + 1;
      // A packet that does not fit the rest of the line is an overrun.
      if (int'(dec_count) + len > int'(dec_cfg.line_width)) begin
        dec_stuck = 1'b1;
        res.error_flag = 1'b1;
        pixel_expect_q.push_back(res);
        return;
      end
      dec_count      = dec_count + 17'(len);
      dec_run        = (b & CTRL_RUN_BIT) != 8'h00;
      dec_len        = 8'(len);
      dec_left       = dec_run ? 8'd1 : 8'(len);
      dec_pixel      = '0;
      dec_pos        = '0;
      dec_await_ctrl = 1'b0;
      return;
    end
    pos = int'(dec_pos);
    dec_pixel = dec_pixel | (32'(b) << (8 * pos));
    // The pixel size is read at every byte, so a smaller size set while a
    // pixel is half gathered completes it on the next byte.
    if (pos + 1 < eff_pixel_bytes(dec_cfg.bytes_per_pixel)) begin
      dec_pos = 2'(pos + 1);
      return;
    end
    res.pixel_value  = dec_pixel;
    res.repeat_count = dec_run ? dec_len : 8'd1;
    dec_pixel = '0;
    dec_pos   = '0;
    if (dec_left != 8'd0) dec_left = dec_left - 8'd1;
    if (dec_left == 8'd0) begin
      dec_await_ctrl = 1'b1;
      // An exactly filled line ends here and the next line starts from zero.
      if (dec_count == 17'(dec_cfg.line_width)) begin
        res.line_end = 1'b1;
        dec_count    = '0;
      end
    end
    pixel_expect_q.push_back(res);
  endtask

  task automatic note_mismatch(input string what, input logic [39:0] want,
                               input logic [39:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t ns: mismatch on %s, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking. Every result transaction is matched against the oldest
  // queued expectation, field by field.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rld_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pixel_expect_q.size() == 0) begin
        note_mismatch("result with none expected", '0, m_axis_tdata);
      end else begin
        want = pixel_expect_q.pop_front();
        if (m_axis_tdata[31:0] !== want.pixel_value) begin
          note_mismatch("pixel_value", 40'(want.pixel_value), 40'(m_axis_tdata[31:0]));
        end
        if (m_axis_tdata[39:32] !== want.repeat_count) begin
          note_mismatch("repeat_count", 40'(want.repeat_count), 40'(m_axis_tdata[39:32]));
        end
        if (m_axis_tlast !== want.line_end) begin
          note_mismatch("line_end", 40'(want.line_end), 40'(m_axis_tlast));
        end
        if (m_axis_tuser[0] !== want.error_flag) begin
          note_mismatch("error_flag", 40'(want.error_flag), 40'(m_axis_tuser[0]));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side back-pressure: mostly short ready or stall stretches with an
  // occasional long stall, unless a phase asks for steady flow.
  // --------------------------------------------------------------------------
  int unsigned ready_hold = 0;

  always @(posedge clk_i) begin
    int unsigned r;
    if (steady_flow) begin
      m_axis_tready <= 1'b1;
      ready_hold = 0;
    end else if (ready_hold != 0) begin
      ready_hold--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        m_axis_tready <= 1'b1;
        ready_hold = $urandom_range(0, 5);
      end else if (r < 93) begin
        m_axis_tready <= 1'b0;
        ready_hold = $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b0;
        ready_hold = $urandom_range(10, 30);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any stretch without a single transaction on either stream or
  // the configuration port ends the run as a failure.
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sends one byte and returns at the edge where it is accepted. tvalid is
  // left high so that a following byte can go out without a bubble.
  task automatic push_byte(input logic [7:0] b, input logic restart);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid   <= 1'b1;
    s_axis_tdata    <= b;
    s_axis_tuser[0] <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_byte(b, restart);
  endtask

  // Holds the input back until every expected result has arrived, then lets
  // the pipeline settle so that register writes land on an idle block.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pixel_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_reg(input logic sel, input logic [31:0] want);
    logic [31:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {sel, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) note_mismatch("register read", 40'(want), 40'(got));
  endtask

  // Writes a register with random bits above its width, then reads it back.
  task automatic program_reg(input logic sel, input logic [15:0] value);
    logic [31:0] data;
    logic [31:0] stored;
    if (sel == REG_LINE_WIDTH) begin
      data   = {16'($urandom), value};
      stored = {16'h0, value};
    end else begin
      data   = {29'($urandom), value[2:0]};
      stored = {29'h0, value[2:0]};
    end
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (sel == REG_LINE_WIDTH) dec_cfg.line_width = data[15:0];
    else dec_cfg.bytes_per_pixel = data[2:0];
    check_reg(sel, stored);
  endtask

  // Sends one packet sized to the rest of the line, now and then one that
  // overruns it. A packet left half done by noise is finished first.
  task automatic send_packet(input logic restart_first);
    int unsigned cnt;
    int unsigned rem;
    int unsigned maxl;
    int unsigned len;
    int unsigned npix;
    int unsigned pb;
    bit          run;
    if (!restart_first) begin
      while (!dec_await_ctrl && !dec_stuck) push_byte(8'($urandom), 1'b0);
      if (dec_stuck) return;
    end
    cnt  = restart_first ? 0 : int'(dec_count);
    rem  = (int'(dec_cfg.line_width) > cnt) ? int'(dec_cfg.line_width) - cnt : 0;
    maxl = (rem < 128) ? rem : 128;
    if (rem == 0) len = $urandom_range(1, 128);
    else if (rem < 128 && $urandom_range(0, 99) < 4) len = $urandom_range(rem + 1, 128);
    else if ($urandom_range(0, 9) == 0) len = $urandom_range(1, maxl);
    else len = $urandom_range(1, (maxl < 8) ? maxl : 8);
    run = 1'($urandom);
    push_byte(ctrl_byte(run, len), restart_first);
    if (dec_stuck) return;
    pb   = eff_pixel_bytes(dec_cfg.bytes_per_pixel);
    npix = run ? 1 : len;
    // A rare restart on a pixel byte breaks the packet in the middle.
    repeat (npix * pb) push_byte(8'($urandom), $urandom_range(0, 199) == 0);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) push_byte(8'($urandom), $urandom_range(0, 9) == 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Reset values, a one pixel line with extreme byte values, an overrun with
  // a dropped byte after it, and recovery through restart.
  task automatic test_reset_defaults();
    check_reg(REG_LINE_WIDTH, 32'(LINE_WIDTH_RESET));
    check_reg(REG_BYTES_PER_PIXEL, 32'(BYTES_PER_PIXEL_RESET));
    push_byte(ctrl_byte(1'b0, 1), 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'ha5, 1'b0);
    push_byte(8'h5a, 1'b0);
    push_byte(ctrl_byte(1'b1, 2), 1'b0);
    push_byte(8'h37, 1'b0);
    push_byte(ctrl_byte(1'b1, 1), 1'b1);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b0);
    push_byte(8'h78, 1'b0);
  endtask

  // Zero width overruns on any packet; the widest line takes a full length
  // run and a raw packet without ending, with a zero pixel size acting as one.
  task automatic test_line_width_extremes();
    wait_idle();
    program_reg(REG_LINE_WIDTH, 16'd0);
    program_reg(REG_BYTES_PER_PIXEL, 16'd1);
    push_byte(ctrl_byte(1'b0, 1), 1'b1);
    wait_idle();
    program_reg(REG_LINE_WIDTH, 16'hffff);
    program_reg(REG_BYTES_PER_PIXEL, 16'd0);
    push_byte(ctrl_byte(1'b1, 128), 1'b1);
    push_byte(8'h7e, 1'b0);
    push_byte(ctrl_byte(1'b0, 2), 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b0);
  endtask

  // A pixel size above the maximum is clamped to four bytes.
  task automatic test_pixel_size_clamp();
    wait_idle();
    program_reg(REG_LINE_WIDTH, 16'd3);
    program_reg(REG_BYTES_PER_PIXEL, 16'd7);
    push_byte(ctrl_byte(1'b1, 3), 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hfe, 1'b0);
    push_byte(8'h7f, 1'b0);
  endtask

  // Three bytes of a four byte pixel are gathered, then the pixel size drops
  // to one: the next byte completes the pixel and the line goes on.
  task automatic test_pixel_size_change_mid_packet();
    wait_idle();
    program_reg(REG_LINE_WIDTH, 16'd2);
    program_reg(REG_BYTES_PER_PIXEL, 16'd4);
    push_byte(ctrl_byte(1'b0, 2), 1'b1);
    push_byte(8'hc3, 1'b0);
    push_byte(8'h3c, 1'b0);
    push_byte(8'h99, 1'b0);
    wait_idle();
    program_reg(REG_BYTES_PER_PIXEL, 16'd1);
    push_byte(8'h66, 1'b0);
    push_byte(8'h11, 1'b0);
  endtask

  // Random lines under changing settings. The parser state carries over from
  // one phase to the next, so new settings also land inside packets.
  task automatic test_random_stream();
    int unsigned phase;
    int unsigned stop_at;
    int unsigned r;
    logic [15:0] width;
    logic [2:0]  bpp;
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      r = $urandom_range(0, 99);
      if (r < 70) width = 16'($urandom_range(1, 40));
      else if (r < 90) width = 16'($urandom_range(41, 600));
      else width = 16'($urandom_range(60000, 65535));
      bpp = 3'($urandom);
      case (phase)
        0: begin
          width = 16'd1;
          bpp   = 3'd1;
        end
        1: begin
          width = 16'hffff;
          bpp   = 3'd4;
        end
        2: begin
          width = 16'd0;
        end
        default: begin
        end
      endcase
      program_reg(REG_LINE_WIDTH, width);
      program_reg(REG_BYTES_PER_PIXEL, 16'(bpp));
      steady_flow = (phase % 4 == 3);
      stop_at = decoded_items + ((phase == 2) ? 40 : RANDOM_ITEMS / PHASES);
      while (decoded_items < stop_at) begin
        if (dec_stuck) begin
          // Dropped bytes after an overrun, then a restart on a control byte.
          repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b0);
          send_packet(1'b1);
        end else if ($urandom_range(0, 99) < 5) begin
          send_noise();
        end else begin
          send_packet(1'b0);
        end
      end
    end
    steady_flow = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    dec_cfg.line_width      = LINE_WIDTH_RESET;
    dec_cfg.bytes_per_pixel = BYTES_PER_PIXEL_RESET;
    clear_line_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_line_width_extremes();
    test_pixel_size_clamp();
    test_pixel_size_change_mid_packet();
    test_random_stream();

    // Drain every outstanding result and give the block time to show any
    // stray one before the verdict.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pixel_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- tga_rle_line_decoder_unit.f -----
hdl/rld_pkg.sv
hdl/rld_cfg_regs.sv
hdl/rld_parser.sv
hdl/rld_out_fifo.sv
hdl/tga_rle_line_decoder_unit.sv
tb/sv/tb_top.sv
